>>> design/spq_pkg.sv
package spq_pkg;

  // Fixed field widths
  localparam int unsigned PrioW   = 16;
  localparam int unsigned HandleW = 32;
  localparam int unsigned TidW    = 8;
  localparam int unsigned PosW    = 4;
  localparam int unsigned StW     = 3;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned StsW    = 2;
  localparam int unsigned PaddrW  = 3;

  // Register index taken from paddr[2]
  localparam logic CfgCreatedState = 1'b0;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD       = 3'd0,
    CMD_REMOVE    = 3'd1,
    CMD_ID_AT_POS = 3'd2,
    CMD_GET_STATE = 3'd3,
    CMD_GET_HDL   = 3'd4,
    CMD_SET_STATE = 3'd5
  } cmd_e;

  typedef enum logic [StsW-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_NOID  = 2'd2,
    STS_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [PrioW-1:0]   prio;
    logic [TidW-1:0]    id;
    logic [StW-1:0]     state;
    logic [HandleW-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic load_new;    // take the incoming task
    logic take_left;   // shift up from lower position
    logic take_right;  // close the gap from higher position
    logic set_state;   // overwrite state only
  } cell_ctrl_t;

  typedef struct packed {
    logic id_hit;      // occupied and id matches
    logic prio_le;     // occupied and own prio <= request
  } cell_flags_t;

endpackage

>>> design/spq_cell.sv
module spq_cell (
  input  logic                       clk_i,
  input  logic                       occupied_i,
  input  logic [spq_pkg::PrioW-1:0]  req_prio_i,
  input  logic [spq_pkg::TidW-1:0]   req_id_i,
  input  logic [spq_pkg::StW-1:0]    new_state_i,
  input  spq_pkg::cell_ctrl_t        ctrl_i,
  input  spq_pkg::entry_t            new_entry_i,
  input  spq_pkg::entry_t            left_entry_i,
  input  spq_pkg::entry_t            right_entry_i,
  output spq_pkg::entry_t            entry_o,
  output spq_pkg::cell_flags_t       flags_o
);

  spq_pkg::entry_t entry_q, entry_d;

  // local compares
  assign flags_o.id_hit  = occupied_i && (entry_q.id == req_id_i);
  assign flags_o.prio_le = occupied_i && !(req_prio_i < entry_q.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load_new) begin
      entry_d = new_entry_i;
    end else if (ctrl_i.take_left) begin
      entry_d = left_entry_i;
    end else if (ctrl_i.take_right) begin
      entry_d = right_entry_i;
    end else if (ctrl_i.set_state) begin
      entry_d.state = new_state_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

>>> design/sorted_priority_task_queue.sv
// Channel   Dir  Beat contents (low bit first)
// s_axis    in   tuser: cmd; tdata: priority_req, entry_handle, task_id,
//                position, new_state, pad
// m_axis    out  tdata: status, out_id, out_state, out_handle, queue_length,
//                is_empty, is_full, pad
// apb       in   reg 0 at 0x0: created_state_code (3 bits)
//
// One command per cycle unless m_axis stalls: every cell compares its own
// entry against the request in parallel and shifts with its neighbor on the same edge.
// The result is registered; it shows in the cycle after the input beat.
// s_axis_tready drops only while a result waits on a stalled m_axis.
// rst_ni is asynchronous; after reset the queue is empty and ids start at 0.
module sorted_priority_task_queue #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ID_MODULUS = 256,
  localparam int unsigned CntW      = $clog2(DEPTH + 1),
  localparam int unsigned OutW      = ((47 + CntW + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // stream in
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [63:0]                  s_axis_tdata,  // prio, handle, id, pos, new_state
  input  logic [spq_pkg::CmdW-1:0]     s_axis_tuser,  // cmd
  // stream out
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [OutW-1:0]              m_axis_tdata,  // status, id, state, handle, len,
                                                      // empty, full
  // config
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spq_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned IdCntW = $clog2(ID_MODULUS);
  localparam int unsigned IdExtW = (IdCntW > 8) ? IdCntW : 8;

  // ---------------------------------------------------------------- config
  logic [spq_pkg::StW-1:0] created_state_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == spq_pkg::CfgCreatedState) ?
                  32'(created_state_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      created_state_q <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == spq_pkg::CfgCreatedState)) begin
      created_state_q <= pwdata[spq_pkg::StW-1:0];
    end
  end

  // ---------------------------------------------------------------- input beat
  logic                          accept;
  spq_pkg::cmd_e                 cmd;
  logic [spq_pkg::PrioW-1:0]     req_prio;
  logic [spq_pkg::HandleW-1:0]   req_handle;
  logic [spq_pkg::TidW-1:0]      req_id;
  logic [spq_pkg::PosW-1:0]      req_pos;
  logic [spq_pkg::StW-1:0]       req_state;

  assign cmd        = spq_pkg::cmd_e'(s_axis_tuser);
  assign req_prio   = s_axis_tdata[15:0];
  assign req_handle = s_axis_tdata[47:16];
  assign req_id     = s_axis_tdata[55:48];
  assign req_pos    = s_axis_tdata[59:56];
  assign req_state  = s_axis_tdata[62:60];

  logic m_valid_q;
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- counters
  logic [CntW-1:0]   occ_q, occ_d;
  logic [IdCntW-1:0] next_id_q;
  logic [IdExtW-1:0] next_id_ext;
  logic [spq_pkg::TidW-1:0] new_id;

  assign next_id_ext = IdExtW'(next_id_q);
  assign new_id      = next_id_ext[7:0];

  // ---------------------------------------------------------------- cell row
  spq_pkg::entry_t      entries  [DEPTH];
  spq_pkg::cell_flags_t flags    [DEPTH];
  spq_pkg::cell_ctrl_t  ctrl     [DEPTH];
  spq_pkg::entry_t      new_entry;
  logic [DEPTH-1:0]     occupied, hit_v, go_v, first_v, tail_v, pos_v;
  logic                 full, found, add_ok, rm_ok, set_go;

  assign new_entry.prio   = req_prio;
  assign new_entry.id     = new_id;
  assign new_entry.state  = created_state_q;
  assign new_entry.handle = req_handle;

  assign full    = (occ_q == CntW'(DEPTH));
  assign found   = |hit_v;
  // lowest matching position, and everything from it upward
  assign first_v = hit_v & (~hit_v + DEPTH'(1));
  assign tail_v  = hit_v | (~hit_v + DEPTH'(1));

  assign add_ok = accept && (cmd == spq_pkg::CMD_ADD) && !full;
  assign rm_ok  = accept && (cmd == spq_pkg::CMD_REMOVE) && found;
  assign set_go = accept && (cmd == spq_pkg::CMD_SET_STATE);

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    spq_pkg::entry_t left_e, right_e;
    logic            go_prev;

    assign occupied[k] = (CntW'(k) < occ_q);
    assign hit_v[k]    = flags[k].id_hit;
    // new task lands at or before this slot
    assign go_v[k]     = !flags[k].prio_le;
    assign pos_v[k]    = (32'(k) == 32'(req_pos));

    if (k == 0) begin : g_first
      assign left_e  = new_entry;
      assign go_prev = 1'b0;
    end else begin : g_mid
      assign left_e  = entries[k-1];
      assign go_prev = go_v[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign right_e = entries[k];
    end else begin : g_nlast
      assign right_e = entries[k+1];
    end

    assign ctrl[k].load_new   = add_ok && go_v[k] && !go_prev;
    assign ctrl[k].take_left  = add_ok && go_v[k] && go_prev;
    assign ctrl[k].take_right = rm_ok && tail_v[k];
    assign ctrl[k].set_state  = set_go && hit_v[k];

    spq_cell u_cell (
      .clk_i         (clk_i),
      .occupied_i    (occupied[k]),
      .req_prio_i    (req_prio),
      .req_id_i      (req_id),
      .new_state_i   (req_state),
      .ctrl_i        (ctrl[k]),
      .new_entry_i   (new_entry),
      .left_entry_i  (left_e),
      .right_entry_i (right_e),
      .entry_o       (entries[k]),
      .flags_o       (flags[k])
    );
  end

  // one-hot reads: first id match, and the slot at the requested position
  logic [spq_pkg::StW-1:0]     hit_state;
  logic [spq_pkg::HandleW-1:0] hit_handle;
  logic [spq_pkg::TidW-1:0]    pos_id;

  always_comb begin
    hit_state  = '0;
    hit_handle = '0;
    pos_id     = '0;
    for (int k = 0; k < DEPTH; k++) begin
      hit_state  = hit_state  | (first_v[k] ? entries[k].state  : '0);
      hit_handle = hit_handle | (first_v[k] ? entries[k].handle : '0);
      pos_id     = pos_id     | (pos_v[k]   ? entries[k].id     : '0);
    end
  end

  // ---------------------------------------------------------------- result
  spq_pkg::status_e            sts;
  logic [spq_pkg::TidW-1:0]    o_id;
  logic [spq_pkg::StW-1:0]     o_state;
  logic [spq_pkg::HandleW-1:0] o_handle;

  always_comb begin
    sts      = spq_pkg::STS_OK;
    o_id     = '0;
    o_state  = '0;
    o_handle = '0;
    unique case (cmd) inside
      spq_pkg::CMD_ADD: begin
        if (full) begin
          sts = spq_pkg::STS_FULL;
        end else begin
          o_id = new_id;
        end
      end
      spq_pkg::CMD_REMOVE, spq_pkg::CMD_SET_STATE: begin
        if (!found) sts = spq_pkg::STS_NOID;
      end
      spq_pkg::CMD_ID_AT_POS: begin
        if (32'(req_pos) >= 32'(occ_q)) begin
          sts = spq_pkg::STS_RANGE;
        end else begin
          o_id = pos_id;
        end
      end
      spq_pkg::CMD_GET_STATE: begin
        if (!found) sts = spq_pkg::STS_NOID;
        else        o_state = hit_state;
      end
      spq_pkg::CMD_GET_HDL: begin
        if (!found) sts = spq_pkg::STS_NOID;
        else        o_handle = hit_handle;
      end
      default: ;  // unused codes: no change, status ok
    endcase
  end

  always_comb begin
    occ_d = occ_q;
    if (add_ok)     occ_d = occ_q + CntW'(1);
    else if (rm_ok) occ_d = occ_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= '0;
      next_id_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (add_ok) begin
        next_id_q <= (next_id_q == IdCntW'(ID_MODULUS - 1)) ?
                     '0 : next_id_q + IdCntW'(1);
      end
      if (accept) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  logic [OutW-1:0] out_data_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= OutW'({(occ_d == CntW'(DEPTH)), (occ_d == '0), occ_d,
                           o_handle, o_state, o_id, sts});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> design/spq_checker.sv
module spq_checker #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned CntW = $clog2(DEPTH + 1),
  localparam int unsigned OutW = ((47 + CntW + 7) / 8) * 8
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tvalid,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata
);

  localparam int unsigned EmptyBit = 45 + CntW;
  localparam int unsigned FullBit  = 46 + CntW;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // each input beat shows a result on the next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("input beat produced no result");

  // input only backs up behind a stalled result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // empty and full never together
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[EmptyBit] && m_axis_tdata[FullBit]))
    else $error("empty and full both set");

endmodule

bind sorted_priority_task_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
